>>> rtl/core/tachometer_period_speed_ascii_assert.svh
// assertion macros for the tachometer checker
`ifndef TACHOMETER_PERIOD_SPEED_ASCII_ASSERT_SVH
`define TACHOMETER_PERIOD_SPEED_ASCII_ASSERT_SVH

// same-cycle implication
`define TPS_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tps check failed");

// next-cycle implication
`define TPS_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tps check failed");

`endif

>>> rtl/core/tps_pkg.sv
// types, constants and microcode for the tachometer
package tps_pkg;

  localparam int CAP_W      = 16;
  localparam int COUNT_W    = 16;
  localparam int SCALE_W    = 24;
  localparam int CHAR_W     = 8;
  localparam int PERIOD_W   = 32;
  localparam int DIV_CNT_W  = 5;
  localparam int NUM_DIGITS = 8;
  localparam int DIGIT_W    = 4;
  localparam int DIGIT_IDX_W = 3;
  localparam int ND_W       = 4;
  localparam int PROD_W     = 56;
  localparam int RECIP_SHIFT = 35;
  localparam int STEP_W     = 3;

  localparam logic [SCALE_W-1:0]   SCALE_RESET  = 24'd125000;
  localparam logic [DIV_CNT_W-1:0] DIV_CNT_INIT = 5'(SCALE_W - 1);
  localparam logic [31:0]          RECIP_TEN    = 32'hCCCCCCCD;
  localparam logic [CHAR_W-1:0]    CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0]    CHAR_NL      = 8'h0A;
  localparam logic                 CMD_TICK     = 1'b0;
  localparam logic                 CMD_EDGE     = 1'b1;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SPEED_LATCH,
    OP_MUL,
    OP_DIGIT,
    OP_EMIT_DIGIT,
    OP_EMIT_NL
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_PERIOD_ZERO,
    COND_CNT_NZ,
    COND_Q_NZ,
    COND_MORE_DIGITS
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic advance;
    logic period_zero;
    logic cnt_nz;
    logic q_nz;
    logic more_digits;
  } status_t;

  localparam step_t STEP_ACCEPT = 3'd0;
  localparam step_t STEP_DIV    = 3'd2;
  localparam step_t STEP_LATCH  = 3'd3;
  localparam step_t STEP_MUL    = 3'd4;
  localparam step_t STEP_EMIT   = 3'd6;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    case (s)
      3'd0: w = '{op: OP_ACCEPT,      cond: COND_NEVER,       target: STEP_ACCEPT};
      3'd1: w = '{op: OP_DIV_INIT,    cond: COND_PERIOD_ZERO, target: STEP_LATCH};
      3'd2: w = '{op: OP_DIV_STEP,    cond: COND_CNT_NZ,      target: STEP_DIV};
      3'd3: w = '{op: OP_SPEED_LATCH, cond: COND_NEVER,       target: STEP_ACCEPT};
      3'd4: w = '{op: OP_MUL,         cond: COND_NEVER,       target: STEP_ACCEPT};
      3'd5: w = '{op: OP_DIGIT,       cond: COND_Q_NZ,        target: STEP_MUL};
      3'd6: w = '{op: OP_EMIT_DIGIT,  cond: COND_MORE_DIGITS, target: STEP_EMIT};
      3'd7: w = '{op: OP_EMIT_NL,     cond: COND_ALWAYS,      target: STEP_ACCEPT};
      default: w = '{op: OP_ACCEPT,   cond: COND_NEVER,       target: STEP_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/tps_ifs.sv
// request and result channel interfaces
interface tps_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [tps_pkg::CAP_W-1:0] capture_value;

  modport source (output valid, output command, output capture_value, input ready);
  modport sink (input valid, input command, input capture_value, output ready);
endinterface

interface tps_out_if;
  logic                        valid;
  logic                        ready;
  logic [tps_pkg::CHAR_W-1:0]  out_char;
  logic [tps_pkg::SCALE_W-1:0] speed_value;
  logic                        last_char;

  modport source (output valid, output out_char, output speed_value, output last_char,
                  input ready);
  modport sink (input valid, input out_char, input speed_value, input last_char,
                output ready);
endinterface

>>> rtl/core/tps_seq.sv
// microcode step counter and control rom
module tps_seq (
  input  logic             clk,
  input  logic             rst,
  input  tps_pkg::status_t status,
  output tps_pkg::ctrl_t   ctrl
);
  import tps_pkg::*;

  step_t step;
  step_t step_next;
  logic  cond_met;

  assign ctrl = ucode(step);

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:       cond_met = 1'b0;
      COND_ALWAYS:      cond_met = 1'b1;
      COND_PERIOD_ZERO: cond_met = status.period_zero;
      COND_CNT_NZ:      cond_met = status.cnt_nz;
      COND_Q_NZ:        cond_met = status.q_nz;
      COND_MORE_DIGITS: cond_met = status.more_digits;
      default:          cond_met = 1'b0;
    endcase
  end

  always_comb begin
    if (!status.advance) begin
      step_next = step;
    end else if (cond_met) begin
      step_next = ctrl.target;
    end else begin
      step_next = step + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_ACCEPT;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> rtl/core/tps_dp.sv
// datapath: period, restoring divider, decimal digits, output register
module tps_dp #(
  parameter int TIMER_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tps_pkg::ctrl_t               ctrl,
  output tps_pkg::status_t             status,
  tps_in_if.sink                       sensor,
  tps_out_if.source                    digits,
  input  logic                         cfg_we,
  input  logic [tps_pkg::SCALE_W-1:0]  cfg_data
);
  import tps_pkg::*;

  localparam int CAP_BITS = (TIMER_BITS < CAP_W) ? TIMER_BITS : CAP_W;
  localparam logic [CAP_W-1:0] CAP_MASK = CAP_W'((64'd1 << CAP_BITS) - 64'd1);
  localparam int PW = (TIMER_BITS + CAP_W + 1 > PERIOD_W + 1) ?
                      TIMER_BITS + CAP_W + 1 : PERIOD_W + 1;

  logic [SCALE_W-1:0]   speed_scale;
  logic [CAP_W-1:0]     last_capture;
  logic [COUNT_W-1:0]   overflow_count;
  logic [PERIOD_W-1:0]  period;
  logic [PERIOD_W-1:0]  rem;
  logic [SCALE_W-1:0]   quot;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SCALE_W-1:0]   speed;
  logic [SCALE_W-1:0]   val;
  logic [SCALE_W-1:0]   q10;
  logic [ND_W-1:0]      nd;
  logic [DIGIT_W-1:0]   digit_mem [NUM_DIGITS];

  logic                 o_valid;
  logic [CHAR_W-1:0]    o_char;
  logic [SCALE_W-1:0]   o_speed;
  logic                 o_last;

  logic                 accepted;
  logic                 edge_taken;
  logic                 tick_taken;
  logic                 can_load;
  logic                 load;
  logic [CAP_W-1:0]     cap_m;
  logic [PW-1:0]        period_sum;
  logic [PERIOD_W-1:0]  period_new;
  logic [PERIOD_W:0]    trial;
  logic                 ge;
  logic [PERIOD_W:0]    trial_diff;
  logic [PROD_W-1:0]    prod;
  logic [SCALE_W-1:0]   rem10;
  logic [DIGIT_IDX_W-1:0] emit_idx;
  logic [ND_W-1:0]      nd_m1;

  assign sensor.ready  = (ctrl.op == OP_ACCEPT);
  assign accepted      = sensor.valid && sensor.ready;
  assign edge_taken    = accepted && (sensor.command == CMD_EDGE);
  assign tick_taken    = accepted && (sensor.command == CMD_TICK);

  assign digits.valid       = o_valid;
  assign digits.out_char    = o_char;
  assign digits.speed_value = o_speed;
  assign digits.last_char   = o_last;

  assign can_load = !o_valid || digits.ready;
  assign load     = can_load && ((ctrl.op == OP_EMIT_DIGIT) || (ctrl.op == OP_EMIT_NL));

  // period from wraps and the two captures
  assign cap_m      = sensor.capture_value & CAP_MASK;
  assign period_sum = (PW'(overflow_count) << TIMER_BITS) + PW'(cap_m) - PW'(last_capture);

  always_comb begin
    if (overflow_count != '0) begin
      period_new = (|period_sum[PW-1:PERIOD_W]) ? '1 : period_sum[PERIOD_W-1:0];
    end else begin
      period_new = PERIOD_W'(period_sum[TIMER_BITS-1:0]);
    end
  end

  // one quotient bit per step
  assign trial      = {rem, quot[SCALE_W-1]};
  assign trial_diff = trial - {1'b0, period};
  assign ge         = (trial >= {1'b0, period});

  // divide by ten through the reciprocal
  assign prod  = PROD_W'(val) * PROD_W'(RECIP_TEN);
  assign rem10 = val - ((q10 << 3) + (q10 << 1));

  assign nd_m1    = nd - ND_W'(1);
  assign emit_idx = nd_m1[DIGIT_IDX_W-1:0];

  always_comb begin
    status.period_zero = (period == '0);
    status.cnt_nz      = (cnt != '0);
    status.q_nz        = (q10 != '0);
    status.more_digits = (nd != ND_W'(1));
    case (ctrl.op)
      OP_ACCEPT:     status.advance = edge_taken;
      OP_EMIT_DIGIT: status.advance = can_load;
      OP_EMIT_NL:    status.advance = can_load;
      default:       status.advance = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale    <= SCALE_RESET;
      last_capture   <= '0;
      overflow_count <= '0;
      o_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        speed_scale <= cfg_data;
      end
      if (tick_taken && (overflow_count != '1)) begin
        overflow_count <= overflow_count + COUNT_W'(1);
      end else if (edge_taken) begin
        overflow_count <= '0;
      end
      if (edge_taken) begin
        last_capture <= cap_m;
      end
      if (load) begin
        o_valid <= 1'b1;
      end else if (digits.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (edge_taken) begin
      period <= period_new;
    end
    if (load) begin
      o_speed <= speed;
      if (ctrl.op == OP_EMIT_NL) begin
        o_char <= CHAR_NL;
        o_last <= 1'b1;
      end else begin
        o_char <= CHAR_ZERO + CHAR_W'(digit_mem[emit_idx]);
        o_last <= 1'b0;
        nd     <= nd_m1;
      end
    end
    case (ctrl.op)
      OP_DIV_INIT: begin
        rem  <= '0;
        quot <= speed_scale;
        cnt  <= DIV_CNT_INIT;
      end
      OP_DIV_STEP: begin
        rem  <= ge ? trial_diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
        quot <= {quot[SCALE_W-2:0], ge};
        cnt  <= cnt - DIV_CNT_W'(1);
      end
      OP_SPEED_LATCH: begin
        speed <= (period == '0) ? '0 : quot;
        val   <= (period == '0) ? '0 : quot;
        nd    <= '0;
      end
      OP_MUL: begin
        q10 <= SCALE_W'(prod >> RECIP_SHIFT);
      end
      OP_DIGIT: begin
        digit_mem[nd[DIGIT_IDX_W-1:0]] <= rem10[DIGIT_W-1:0];
        nd  <= nd + ND_W'(1);
        val <= q10;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/tachometer_period_speed_ascii.sv
// Period-measuring tachometer with ASCII decimal speed output.
//
// sensor channel: one request per event. command 0 is a timer overflow tick,
// counted with saturation at 65535. command 1 is a sensor edge with the timer
// capture; it closes the period, clears the tick count and keeps the capture.
// digits channel: per edge, the speed speed_scale / period as ASCII digits,
// most significant first, then a newline with last_char high. speed_value
// carries the binary speed on every item of the run. A zero period gives "0".
// cfg_we / cfg_data write speed_scale; the user must do so while the block is
// idle, which the block itself does not enforce. A tick is taken in the accept
// step without leaving it. An edge runs the microcode: a setup step, the
// restoring divider at one quotient bit per cycle over 24 quotient bits, a
// step to latch the speed, a reciprocal multiply step and a remainder step per
// digit, then one character loaded per cycle unless digits.ready stalls. A zero
// period skips the divider. sensor.ready stays low from the edge until the
// newline is loaded. A stalled digits.ready holds the output register and the
// sequencer waits on the emit step. Reset returns speed_scale to 125000 and
// clears the previous capture, the tick count and the output valid flag.
module tachometer_period_speed_ascii #(
  parameter int TIMER_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  tps_in_if.sink                      sensor,
  tps_out_if.source                   digits,
  input  logic                        cfg_we,
  input  logic [tps_pkg::SCALE_W-1:0] cfg_data
);
  import tps_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  tps_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  tps_dp #(
    .TIMER_BITS (TIMER_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .status   (status),
    .sensor   (sensor),
    .digits   (digits),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

endmodule

>>> rtl/core/tps_checker.sv
// port-level checks for the tachometer, bound to the top level
`include "tachometer_period_speed_ascii_assert.svh"

module tps_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_command,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tps_pkg::CHAR_W-1:0] out_char,
  input logic                       out_last
);
  import tps_pkg::*;

  // held result until taken
  `TPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char))
  // run ends in a newline
  `TPS_ASSERT_NOW(a_last_nl, out_valid && out_last, out_char == CHAR_NL)
  // other characters are decimal digits
  `TPS_ASSERT_NOW(a_digit, out_valid && !out_last,
                  (out_char >= CHAR_ZERO) && (out_char <= CHAR_ZERO + CHAR_W'(9)))
  // no new request while an edge is being worked
  `TPS_ASSERT_NEXT(a_busy, in_valid && in_ready && (in_command == CMD_EDGE), !in_ready)

endmodule

bind tachometer_period_speed_ascii tps_checker u_tps_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (sensor.valid),
  .in_ready   (sensor.ready),
  .in_command (sensor.command),
  .out_valid  (digits.valid),
  .out_ready  (digits.ready),
  .out_char   (digits.out_char),
  .out_last   (digits.last_char)
);

>>> dv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the tachometer: directed table and random phases
module testbench;
  import tps_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_LEN    = 400;
  localparam int TAIL_CYCLES = 60;
  localparam int TICK_SETTLE = 8;
  localparam int PHASE_ITEMS = 20;

  typedef enum logic [1:0] {ROW_TICK, ROW_EDGE, ROW_SCALE} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [SCALE_W-1:0]  arg;
    logic                typed;
    logic [SCALE_W-1:0]  want;
  } row_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [SCALE_W-1:0] speed;
    logic               last;
  } speed_char_t;

  localparam row_t DIRECTED [0:20] = '{
    '{ROW_EDGE,  24'h000000, 1'b1, 24'd0},
    '{ROW_EDGE,  24'h000001, 1'b1, 24'd125000},
    '{ROW_EDGE,  24'h000000, 1'b1, 24'd1},
    '{ROW_TICK,  24'h000000, 1'b0, 24'd0},
    '{ROW_EDGE,  24'h000000, 1'b0, 24'd0},
    '{ROW_TICK,  24'h000000, 1'b0, 24'd0},
    '{ROW_TICK,  24'h000000, 1'b0, 24'd0},
    '{ROW_TICK,  24'h000000, 1'b0, 24'd0},
    '{ROW_EDGE,  24'h00FFFF, 1'b0, 24'd0},
    '{ROW_SCALE, 24'hFFFFFF, 1'b0, 24'd0},
    '{ROW_EDGE,  24'h000000, 1'b1, 24'hFFFFFF},
    '{ROW_EDGE,  24'h000001, 1'b1, 24'hFFFFFF},
    '{ROW_EDGE,  24'h005555, 1'b0, 24'd0},
    '{ROW_EDGE,  24'h00AAAA, 1'b0, 24'd0},
    '{ROW_SCALE, 24'h000001, 1'b0, 24'd0},
    '{ROW_EDGE,  24'h00AAAB, 1'b1, 24'd1},
    '{ROW_EDGE,  24'h00AAAB, 1'b1, 24'd0},
    '{ROW_EDGE,  24'h00AAAA, 1'b1, 24'd0},
    '{ROW_SCALE, 24'd125000, 1'b0, 24'd0},
    '{ROW_EDGE,  24'h007FFF, 1'b0, 24'd0},
    '{ROW_EDGE,  24'h008000, 1'b1, 24'd125000}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [SCALE_W-1:0] cfg_data = '0;

  tps_in_if  sensor_if ();
  tps_out_if digits_if ();

  tachometer_period_speed_ascii dut (
    .clk      (clk),
    .rst      (rst),
    .sensor   (sensor_if),
    .digits   (digits_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  logic [SCALE_W-1:0] scale_setting = SCALE_RESET;
  logic [CAP_W-1:0]   prev_capture = '0;
  logic [COUNT_W-1:0] wrap_count = '0;
  speed_char_t        expected_chars [$];

  int error_count = 0;
  int cycle_count = 0;
  int edge_total = 0;
  int tick_total = 0;
  int char_total = 0;
  int scale_total = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_char(input speed_char_t got);
    speed_char_t exp_c;
    char_total++;
    if (expected_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected char 0x%02h speed %0d", got.ch, got.speed));
    end else begin
      exp_c = expected_chars.pop_front();
      if (got.ch !== exp_c.ch)
        report_mismatch($sformatf("out_char 0x%02h, want 0x%02h", got.ch, exp_c.ch));
      if (got.speed !== exp_c.speed)
        report_mismatch($sformatf("speed_value %0d, want %0d", got.speed, exp_c.speed));
      if (got.last !== exp_c.last)
        report_mismatch($sformatf("last_char %b, want %b", got.last, exp_c.last));
    end
  endtask

  // long receiver hold, counted in cycles
  always @(posedge clk) begin
    if (hold_asked != hold_seen) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // digits side: check accepted chars, drive ready with random stalls and long holds
  always @(posedge clk) begin
    if (!rst && digits_if.valid && digits_if.ready)
      check_char('{ch: digits_if.out_char, speed: digits_if.speed_value,
                   last: digits_if.last_char});
    if (hold_left > 0) begin
      digits_if.ready <= 1'b0;
    end else begin
      digits_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void predict_tick();
    if (wrap_count != {COUNT_W{1'b1}})
      wrap_count = wrap_count + COUNT_W'(1);
  endfunction

  function automatic logic [SCALE_W-1:0] predict_edge(input logic [CAP_W-1:0] cap);
    logic [63:0]         span;
    logic [PERIOD_W-1:0] period;
    logic [CAP_W-1:0]    diff;
    logic [31:0]         quotient;
    diff = cap - prev_capture;
    if (wrap_count != '0) begin
      span = 64'(wrap_count) * 64'h1_0000 + 64'(cap) - 64'(prev_capture);
      period = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
    end else begin
      period = {16'd0, diff};
    end
    quotient = (period != '0) ? 32'(scale_setting) / period : 32'd0;
    wrap_count = '0;
    prev_capture = cap;
    return quotient[SCALE_W-1:0];
  endfunction

  task automatic queue_speed_chars(input logic [SCALE_W-1:0] speed);
    logic [CHAR_W-1:0] text [$];
    int unsigned       v;
    v = 32'(speed);
    do begin
      text.push_front(CHAR_ZERO + CHAR_W'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (text[i])
      expected_chars.push_back('{ch: text[i], speed: speed, last: 1'b0});
    expected_chars.push_back('{ch: CHAR_NL, speed: speed, last: 1'b1});
  endtask

  task automatic send_request(input logic cmd, input logic [CAP_W-1:0] cap);
    while ($urandom_range(99) < idle_pct) begin
      sensor_if.valid <= 1'b0;
      @(posedge clk);
    end
    sensor_if.valid <= 1'b1;
    sensor_if.command <= cmd;
    sensor_if.capture_value <= cap;
    @(posedge clk);
    while (!sensor_if.ready) @(posedge clk);
  endtask

  task automatic send_tick();
    send_request(CMD_TICK, CAP_W'($urandom));
    predict_tick();
    tick_total++;
  endtask

  task automatic send_edge(input logic [CAP_W-1:0] cap, input logic typed,
                           input logic [SCALE_W-1:0] want);
    logic [SCALE_W-1:0] speed;
    send_request(CMD_EDGE, cap);
    speed = predict_edge(cap);
    queue_speed_chars(typed ? want : speed);
    edge_total++;
  endtask

  task automatic wait_drain();
    sensor_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TICK_SETTLE) @(posedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] value);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    scale_setting = value;
    scale_total++;
  endtask

  task automatic random_request();
    logic [CAP_W-1:0] cap;
    if ($urandom_range(99) < 25) begin
      send_tick();
    end else begin
      case ($urandom_range(2))
        0:       cap = CAP_W'($urandom);
        1:       cap = prev_capture + CAP_W'($urandom_range(0, 64));
        default: cap = prev_capture + CAP_W'($urandom_range(1, 4000));
      endcase
      send_edge(cap, 1'b0, '0);
    end
  endtask

  initial begin
    logic [SCALE_W-1:0] phase_scale [0:4];
    int                 phase_idle [0:4];
    int                 phase_stall [0:4];
    sensor_if.valid = 1'b0;
    sensor_if.command = CMD_TICK;
    sensor_if.capture_value = '0;
    phase_scale = '{SCALE_RESET, 24'hFFFFFF, 24'd1, SCALE_W'($urandom_range(1, 24'hFFFFFF)),
                    SCALE_W'($urandom_range(1, 5000))};
    phase_idle  = '{0, 56, 0, 9, 0};
    phase_stall = '{0, 0, 56, 9, 0};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[r]) begin
      case (DIRECTED[r].kind)
        ROW_TICK:  send_tick();
        ROW_EDGE:  send_edge(DIRECTED[r].arg[CAP_W-1:0], DIRECTED[r].typed, DIRECTED[r].want);
        ROW_SCALE: write_scale(DIRECTED[r].arg);
        default:   ;
      endcase
    end

    for (int p = 0; p < 5; p++) begin
      write_scale(phase_scale[p]);
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 0) hold_asked++;
      repeat (PHASE_ITEMS) random_request();
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d sensor edges, %0d overflow ticks, %0d scale writes",
             edge_total, tick_total, scale_total);
    $display("checked %0d speed characters, incl. a long output hold and idle mixes",
             char_total);
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tps_pkg.sv
rtl/core/tps_ifs.sv
rtl/core/tps_seq.sv
rtl/core/tps_dp.sv
rtl/core/tachometer_period_speed_ascii.sv
rtl/core/tps_checker.sv
dv/testbench.sv
